// File: rtl/heat_diffusion_stencil_step_unit_assert.svh
// Assertion macros shared by the stencil step unit
`ifndef HEAT_DIFFUSION_STENCIL_STEP_UNIT_ASSERT_SVH
`define HEAT_DIFFUSION_STENCIL_STEP_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define HDS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define HDS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/hds_pkg.sv
// Shared constants and types of the heat diffusion stencil step unit
package hds_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int MAX_ROWS   = 1024;
	localparam int VAL_W      = 32;
	localparam int K_W        = 16;
	localparam int DIM_W      = 11;
	localparam int CFG_DATA_W = 32;
	localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	// reset values of the configuration registers
	localparam int RST_DIM  = 1024;
	localparam int RST_RATE = 256;
	localparam int RST_BASE = 0;

	// arithmetic widths: 8-term sum, k*sum product, accumulator
	localparam int SUM_W      = VAL_W + 3;
	localparam int PROD_W     = SUM_W + K_W + 1;
	localparam int ACC_W      = PROD_W + 1;
	localparam int OWN_SHIFT  = 11;
	localparam int FRAC_SHIFT = 12;

	typedef logic signed [VAL_W-1:0] hds_val_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_GRID_COLUMNS  = 2'd0,
		REG_GRID_ROWS     = 2'd1,
		REG_TRANSFER_RATE = 2'd2,
		REG_BASE_TEMP     = 2'd3
	} hds_reg_t;

	// input item kinds
	typedef enum logic {
		OP_CELL  = 1'b0,
		OP_DRAIN = 1'b1
	} hds_op_t;

	// one column of the 3x3 window
	typedef struct packed {
		hds_val_t top;
		hds_val_t mid;
		hds_val_t bot;
	} hds_col_t;

	// grid edges around the output cell, plus end of frame
	typedef struct packed {
		logic top;
		logic bot;
		logic left;
		logic right;
		logic last;
	} hds_bnd_t;

endpackage

// File: rtl/hds_if.sv
// Stream and configuration channel interfaces of the stencil step unit
interface hds_in_if;
	import hds_pkg::*;
	logic     valid;
	logic     ready;
	hds_op_t  op;
	hds_val_t cell_value;
	modport source (output valid, output op, output cell_value, input ready);
	modport sink (input valid, input op, input cell_value, output ready);
endinterface

interface hds_out_if;
	import hds_pkg::*;
	logic     valid;
	logic     ready;
	hds_val_t new_value;
	logic     last_of_frame;
	modport source (output valid, output new_value, output last_of_frame, input ready);
	modport sink (input valid, input new_value, input last_of_frame, output ready);
endinterface

interface hds_cfg_if;
	import hds_pkg::*;
	logic                  valid;
	logic                  ready;
	hds_reg_t              index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/hds_line_ram.sv
// One line store: simple dual-port RAM with registered read data
module hds_line_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [hds_pkg::COL_W-1:0]  waddr,
	input  hds_pkg::hds_val_t          wdata,
	input  logic                       re,
	input  logic [hds_pkg::COL_W-1:0]  raddr,
	output hds_pkg::hds_val_t          rdata
);
	import hds_pkg::*;

	hds_val_t mem [MAX_COLS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/hds_win_cell.sv
// One column cell of the 3x3 window; takes its right neighbor's column on shift
module hds_win_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  hds_pkg::hds_col_t col_in,
	output hds_pkg::hds_col_t col_out
);
	import hds_pkg::*;

	hds_col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

// File: rtl/hds_calc.sv
// Stencil arithmetic pipeline: edge masking, 8-term sum, k scaling, rounding, saturation
module hds_calc (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vin,
	output logic                      rdy,
	input  hds_pkg::hds_col_t         c0,
	input  hds_pkg::hds_col_t         c1,
	input  hds_pkg::hds_col_t         c2,
	input  hds_pkg::hds_bnd_t         bnd,
	input  hds_pkg::hds_val_t         base,
	input  logic [hds_pkg::K_W-1:0]   k,
	output logic                      o_valid,
	input  logic                      o_ready,
	output hds_pkg::hds_val_t         o_value,
	output logic                      o_last
);
	import hds_pkg::*;

	localparam int RES_W = ACC_W - FRAC_SHIFT;

	hds_val_t nb [8];

	logic signed [VAL_W:0]    p_s3 [4];
	logic signed [VAL_W+1:0]  q_s4 [2];
	logic signed [SUM_W-1:0]  sum_s5;
	logic signed [PROD_W-1:0] prod_s6;
	hds_val_t own_s3, own_s4, own_s5, own_s6;
	logic last_s3, last_s4, last_s5, last_s6;
	logic v_s3, v_s4, v_s5, v_s6;
	logic rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_o;

	logic signed [K_W:0]      k_sx;
	logic signed [ACC_W-1:0]  acc;
	logic [RES_W-1:0]         res;
	logic                     fits;
	hds_val_t                 sat_val;

	logic     o_valid_q;
	hds_val_t o_value_q;
	logic     o_last_q;

	// stall chain: a stage takes a beat when empty or when it moves on
	assign rdy_o  = !o_valid_q || o_ready;
	assign rdy_s6 = !v_s6 || rdy_o;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy    = rdy_s3;

	// neighbors outside the grid read as the base temperature
	always_comb begin
		nb[0] = (bnd.top || bnd.left)  ? base : c0.top;
		nb[1] = bnd.top                ? base : c1.top;
		nb[2] = (bnd.top || bnd.right) ? base : c2.top;
		nb[3] = bnd.left               ? base : c0.mid;
		nb[4] = bnd.right              ? base : c2.mid;
		nb[5] = (bnd.bot || bnd.left)  ? base : c0.bot;
		nb[6] = bnd.bot                ? base : c1.bot;
		nb[7] = (bnd.bot || bnd.right) ? base : c2.bot;
	end

	assign k_sx = {1'b0, k};

	// floor((k*S + own*2048) / 4096), then clamp to 32 bits
	assign acc     = ACC_W'(prod_s6) + (ACC_W'(own_s6) <<< OWN_SHIFT);
	assign res     = acc[ACC_W-1:FRAC_SHIFT];
	assign fits    = (&res[RES_W-1:VAL_W-1]) || !(|res[RES_W-1:VAL_W-1]);
	assign sat_val = res[RES_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= vin;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_o)  o_valid_q <= v_s6;
		end
	end

	// datapath: pair sums, quad sums, total, product, result
	always_ff @(posedge clk) begin
		if (rdy_s3 && vin) begin
			for (int i = 0; i < 4; i++) begin
				p_s3[i] <= (VAL_W+1)'(nb[2*i]) + (VAL_W+1)'(nb[2*i+1]);
			end
			own_s3  <= c1.mid;
			last_s3 <= bnd.last;
		end
		if (rdy_s4 && v_s3) begin
			for (int j = 0; j < 2; j++) begin
				q_s4[j] <= (VAL_W+2)'(p_s3[2*j]) + (VAL_W+2)'(p_s3[2*j+1]);
			end
			own_s4  <= own_s3;
			last_s4 <= last_s3;
		end
		if (rdy_s5 && v_s4) begin
			sum_s5  <= SUM_W'(q_s4[0]) + SUM_W'(q_s4[1]);
			own_s5  <= own_s4;
			last_s5 <= last_s4;
		end
		if (rdy_s6 && v_s5) begin
			prod_s6 <= PROD_W'(sum_s5) * PROD_W'(k_sx);
			own_s6  <= own_s5;
			last_s6 <= last_s5;
		end
		if (rdy_o && v_s6) begin
			o_value_q <= fits ? res[VAL_W-1:0] : sat_val;
			o_last_q  <= last_s6;
		end
	end

	assign o_valid = o_valid_q;
	assign o_value = o_value_q;
	assign o_last  = o_last_q;

endmodule

// File: rtl/heat_diffusion_stencil_step_unit.sv
// Heat diffusion 3x3 stencil step unit: line stores, window cell chain, arithmetic pipeline.
// Throughput: one item per clock; the input stalls only when the result pipeline is full.
// A result loads the output register once the item at stream position n + columns + 1 has
// passed the line RAM read, the window cells and the four arithmetic stages.
// Reset clears counters, valid bits, window cells and loads the register defaults; the line
// RAMs are not cleared, their unwritten rows lie outside the grid and are masked.
`include "heat_diffusion_stencil_step_unit_assert.svh"

module heat_diffusion_stencil_step_unit (
	input logic       clk,
	input logic       arst_n,
	hds_in_if.sink    cell_in,
	hds_out_if.source result_out,
	hds_cfg_if.sink   cfg
);
	import hds_pkg::*;

	typedef enum logic [1:0] {
		PH_ROW0 = 2'd0,
		PH_ROW1 = 2'd1,
		PH_ROWN = 2'd2
	} row_ph_t;

	// last valid column index for a column register value
	function automatic logic [COL_W-1:0] last_col_of(input logic [DIM_W-1:0] d);
		logic [COL_W-1:0] r;
		if (d == '0) begin
			r = '0;
		end else if (32'(d) > MAX_COLS) begin
			r = COL_W'(MAX_COLS - 1);
		end else begin
			r = COL_W'(32'(d) - 1);
		end
		return r;
	endfunction

	// last valid row index for a row register value
	function automatic logic [ROW_W-1:0] last_row_of(input logic [DIM_W-1:0] d);
		logic [ROW_W-1:0] r;
		if (d == '0) begin
			r = '0;
		end else if (32'(d) > MAX_ROWS) begin
			r = ROW_W'(MAX_ROWS - 1);
		end else begin
			r = ROW_W'(32'(d) - 1);
		end
		return r;
	endfunction

	// configuration
	logic [COL_W-1:0] last_col_q;
	logic [ROW_W-1:0] last_row_q;
	logic [K_W-1:0]   k_q;
	hds_val_t         base_q;

	// stream position and output cell counters
	logic [COL_W-1:0] col_q;
	row_ph_t          rowph_q;
	logic [COL_W-1:0] cc_q;
	logic [ROW_W-1:0] cr_q;

	logic     cfg_acc, acc_in, restart, emit, is_last, byp_d;
	hds_val_t val_in;
	hds_bnd_t bnd_d;

	// stage 1: line RAM read
	logic             v_s1, emit_s1, byp_s1;
	hds_val_t         val_s1, fwd_up_s1, fwd_mid_s1, up_rd, mid_rd, up_eff, mid_eff;
	logic [COL_W-1:0] addr_s1;
	hds_bnd_t         bnd_s1;

	// stage 2: window
	logic     v_s2, emit_s2;
	hds_bnd_t bnd_s2;
	hds_col_t col_new, col2, col1, col0;

	logic rdy1, rdy2, mv1, calc_rdy;

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign restart   = cfg_acc && (cfg.index == REG_GRID_COLUMNS || cfg.index == REG_GRID_ROWS);

	assign acc_in  = cell_in.valid && cell_in.ready;
	assign val_in  = (cell_in.op == OP_DRAIN) ? base_q : cell_in.cell_value;
	assign emit    = (rowph_q == PH_ROWN) || (rowph_q == PH_ROW1 && col_q != '0);
	assign is_last = (cr_q == last_row_q) && (cc_q == last_col_q);

	assign bnd_d.top   = (cr_q == '0);
	assign bnd_d.bot   = (cr_q == last_row_q);
	assign bnd_d.left  = (cc_q == '0);
	assign bnd_d.right = (cc_q == last_col_q);
	assign bnd_d.last  = is_last;

	// stall chain; items that give no result just pass the window
	assign rdy2          = !v_s2 || !emit_s2 || calc_rdy;
	assign mv1           = v_s1 && rdy2;
	assign rdy1          = !v_s1 || rdy2;
	assign cell_in.ready = rdy1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= last_col_of(DIM_W'(RST_DIM));
			last_row_q <= last_row_of(DIM_W'(RST_DIM));
			k_q        <= K_W'(RST_RATE);
			base_q     <= VAL_W'(RST_BASE);
		end else if (cfg_acc) begin
			unique case (cfg.index)
				REG_GRID_COLUMNS:  last_col_q <= last_col_of(cfg.data[DIM_W-1:0]);
				REG_GRID_ROWS:     last_row_q <= last_row_of(cfg.data[DIM_W-1:0]);
				REG_TRANSFER_RATE: k_q        <= cfg.data[K_W-1:0];
				REG_BASE_TEMP:     base_q     <= cfg.data[VAL_W-1:0];
			endcase
		end
	end

	// stream position and output cell counters; the frame restarts after its last cell or on a dimension write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			rowph_q <= PH_ROW0;
			cc_q    <= '0;
			cr_q    <= '0;
		end else if (restart || (acc_in && emit && is_last)) begin
			col_q   <= '0;
			rowph_q <= PH_ROW0;
			cc_q    <= '0;
			cr_q    <= '0;
		end else if (acc_in) begin
			if (col_q == last_col_q) begin
				col_q <= '0;
				unique case (rowph_q)
					PH_ROW0: rowph_q <= PH_ROW1;
					PH_ROW1: rowph_q <= PH_ROWN;
					PH_ROWN: rowph_q <= PH_ROWN;
					default: rowph_q <= PH_ROWN;
				endcase
			end else begin
				col_q <= col_q + 1'b1;
			end
			if (emit) begin
				if (cc_q == last_col_q) begin
					cc_q <= '0;
					cr_q <= cr_q + 1'b1;
				end else begin
					cc_q <= cc_q + 1'b1;
				end
			end
		end
	end

	// line stores: upper takes the old middle entry, middle takes the new value
	hds_line_ram u_ram_upper (
		.clk   (clk),
		.we    (mv1),
		.waddr (addr_s1),
		.wdata (mid_eff),
		.re    (acc_in),
		.raddr (col_q),
		.rdata (up_rd)
	);

	hds_line_ram u_ram_middle (
		.clk   (clk),
		.we    (mv1),
		.waddr (addr_s1),
		.wdata (val_s1),
		.re    (acc_in),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	// forward the entry written in the same cycle as the read
	assign byp_d   = mv1 && (col_q == addr_s1);
	assign up_eff  = byp_s1 ? fwd_up_s1 : up_rd;
	assign mid_eff = byp_s1 ? fwd_mid_s1 : mid_rd;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= cell_in.valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (acc_in) begin
			val_s1     <= val_in;
			addr_s1    <= col_q;
			emit_s1    <= emit;
			bnd_s1     <= bnd_d;
			byp_s1     <= byp_d;
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= val_s1;
		end
		if (mv1) begin
			emit_s2 <= emit_s1;
			bnd_s2  <= bnd_s1;
		end
	end

	// window cell chain, newest column on the right
	assign col_new.top = up_eff;
	assign col_new.mid = mid_eff;
	assign col_new.bot = val_s1;

	hds_win_cell u_cell2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (mv1),
		.col_in  (col_new),
		.col_out (col2)
	);

	hds_win_cell u_cell1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (mv1),
		.col_in  (col2),
		.col_out (col1)
	);

	hds_win_cell u_cell0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (mv1),
		.col_in  (col1),
		.col_out (col0)
	);

	// arithmetic and output register
	hds_calc u_calc (
		.clk     (clk),
		.arst_n  (arst_n),
		.vin     (v_s2 && emit_s2),
		.rdy     (calc_rdy),
		.c0      (col0),
		.c1      (col1),
		.c2      (col2),
		.bnd     (bnd_s2),
		.base    (base_q),
		.k       (k_q),
		.o_valid (result_out.valid),
		.o_ready (result_out.ready),
		.o_value (result_out.new_value),
		.o_last  (result_out.last_of_frame)
	);

	// checks
	`HDS_ASSERT_IMP(a_col_in_range, 1'b1, col_q <= last_col_q, "input column past row end")
	`HDS_ASSERT_IMP(a_out_cell_in_grid, 1'b1, (cc_q <= last_col_q) && (cr_q <= last_row_q), "output cell counter outside grid")
	`HDS_ASSERT_NXT(a_frame_restart, acc_in && emit && is_last, (col_q == '0) && (cc_q == '0) && (cr_q == '0) && (rowph_q == PH_ROW0), "frame did not restart after last cell")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the heat diffusion stencil step unit
`timescale 1ns / 100ps

module tb_top;
	import hds_pkg::*;

	localparam int RANDOM_ITEMS = 540;
	localparam int MIN_PHASES = 6;
	localparam int TALL_ITEMS = 40;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	// one expected output beat
	typedef struct packed {
		hds_val_t value;
		logic     last_flag;
	} cell_result_t;

	// Tracks grid state, predicts each new temperature and checks output beats
	class diffusion_scoreboard;
		int unsigned  cols_reg, rows_reg, rate_reg;
		hds_val_t     base_reg;
		hds_val_t     upper_line[MAX_COLS];
		hds_val_t     middle_line[MAX_COLS];
		hds_val_t     stencil_win[9];
		int unsigned  col_idx, row_idx, emitted;
		cell_result_t expected_cells[$];
		int           mismatches;

		function new();
			cols_reg = RST_DIM;
			rows_reg = RST_DIM;
			rate_reg = RST_RATE;
			base_reg = RST_BASE;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			foreach (stencil_win[i]) stencil_win[i] = '0;
			restart_frame();
			mismatches = 0;
		endfunction

		function void restart_frame();
			col_idx = 0;
			row_idx = 0;
			emitted = 0;
		endfunction

		// zero means one, anything past the limit means the limit
		function int unsigned clamp_dim(int unsigned d, int unsigned limit);
			if (d == 0) return 1;
			if (d > limit) return limit;
			return d;
		endfunction

		function void write_reg(hds_reg_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_GRID_COLUMNS: begin
					cols_reg = d[DIM_W-1:0];
					restart_frame();
				end
				REG_GRID_ROWS: begin
					rows_reg = d[DIM_W-1:0];
					restart_frame();
				end
				REG_TRANSFER_RATE: rate_reg = d[K_W-1:0];
				REG_BASE_TEMP: base_reg = d;
				default: ;
			endcase
		endfunction

		// one accepted input beat; may complete the stencil of an earlier cell
		function void accept_cell(hds_op_t op, hds_val_t cell_val);
			int unsigned  ncols, nrows, total, c, n, cr, cc;
			int           r, dr, dc;
			hds_val_t     val, up, mid;
			longint       pos, sum, acc, res;
			bit           in_grid;
			cell_result_t e;
			ncols = clamp_dim(cols_reg, MAX_COLS);
			nrows = clamp_dim(rows_reg, MAX_ROWS);
			total = ncols * nrows;
			val = (op == OP_DRAIN) ? base_reg : cell_val;
			c = (col_idx >= MAX_COLS) ? 0 : col_idx;

			// line stores shift one row down at this column
			up = upper_line[c];
			mid = middle_line[c];
			upper_line[c] = mid;
			middle_line[c] = val;

			// window moves one column left, new column enters on the right
			for (r = 0; r < 3; r++) begin
				stencil_win[r*3] = stencil_win[r*3+1];
				stencil_win[r*3+1] = stencil_win[r*3+2];
			end
			stencil_win[2] = up;
			stencil_win[5] = mid;
			stencil_win[8] = val;

			pos = longint'(row_idx) * ncols + col_idx;
			col_idx++;
			if (col_idx >= ncols) begin
				col_idx = 0;
				row_idx++;
			end

			if (pos >= longint'(ncols) + 1 && emitted < total) begin
				n = emitted;
				cr = n / ncols;
				cc = n % ncols;
				sum = 0;
				for (dr = 0; dr < 3; dr++) begin
					for (dc = 0; dc < 3; dc++) begin
						if (dr != 1 || dc != 1) begin
							in_grid = (dr != 0 || cr > 0) && (dr != 2 || cr + 1 < nrows) &&
								(dc != 0 || cc > 0) && (dc != 2 || cc + 1 < ncols);
							sum += in_grid ? longint'(stencil_win[dr*3+dc]) : longint'(base_reg);
						end
					end
				end
				// floor((k*S + own*2048) / 4096), then saturate
				acc = longint'(rate_reg) * sum + longint'(stencil_win[4]) * 2048;
				res = acc >>> 12;
				if (res > SAT_HI) res = SAT_HI;
				else if (res < SAT_LO) res = SAT_LO;
				e.value = res[31:0];
				e.last_flag = (n + 1 == total);
				expected_cells.push_back(e);
				emitted++;
				if (emitted >= total) restart_frame();
			end
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
		endfunction

		function void check_cell(hds_val_t value, logic last_flag);
			cell_result_t e;
			if (expected_cells.size() == 0) begin
				report($sformatf("unexpected result value %08h last %0b", value, last_flag));
			end else begin
				e = expected_cells.pop_front();
				if (e.value !== value || e.last_flag !== last_flag)
					report($sformatf("mismatch: expected value %08h last %0b, got value %08h last %0b",
						e.value, e.last_flag, value, last_flag));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hds_in_if  cell_if();
	hds_out_if res_if();
	hds_cfg_if cfg_if();

	diffusion_scoreboard sb = new();

	bit steady = 1'b0;
	bit hold_request = 1'b0;
	int unsigned items_sent = 0;

	heat_diffusion_stencil_step_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_in    (cell_if),
		.result_out (res_if),
		.cfg        (cfg_if)
	);

	always #10 clk = ~clk;

	// run limit
	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls, a long hold-off on request, check each beat
	initial begin
		int hold_left;
		hold_left = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready)
				sb.check_cell(res_if.new_value, res_if.last_of_frame);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= steady || ($urandom_range(99, 0) >= 19);
			end
		end
	end

	// one input beat, with a random gap in front of it
	task automatic send_item(input hds_op_t op, input hds_val_t v);
		while (!steady && $urandom_range(99, 0) < 19) begin
			cell_if.valid <= 1'b0;
			@(posedge clk);
		end
		cell_if.valid <= 1'b1;
		cell_if.op <= op;
		cell_if.cell_value <= v;
		@(posedge clk);
		while (!cell_if.ready) @(posedge clk);
		sb.accept_cell(op, v);
		items_sent++;
	endtask

	task automatic write_reg(input hds_reg_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= d;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		sb.write_reg(idx, d);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_grid(input int unsigned cols, input int unsigned rows,
			input int unsigned rate, input logic [31:0] base);
		write_reg(REG_GRID_COLUMNS, cols);
		write_reg(REG_GRID_ROWS, rows);
		write_reg(REG_TRANSFER_RATE, rate);
		write_reg(REG_BASE_TEMP, base);
	endtask

	// stop sending, let every expected beat arrive, then let the pipeline empty
	task automatic wait_drained();
		cell_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_cells.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic hds_val_t pick_temperature();
		int unsigned sel;
		sel = $urandom_range(99, 0);
		if (sel < 60) return $urandom_range(32'h00FF_FFFF, 0) - 32'h0080_0000;
		if (sel < 85) return $urandom();
		case ($urandom_range(3, 0))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// whole grid in raster order, then columns + 1 trailing beats, mostly drains; a few early drains
	task automatic send_frame();
		int unsigned ncols, total, i;
		ncols = sb.clamp_dim(sb.cols_reg, MAX_COLS);
		total = ncols * sb.clamp_dim(sb.rows_reg, MAX_ROWS);
		for (i = 0; i < total; i++)
			if ($urandom_range(99, 0) < 3) send_item(OP_DRAIN, $urandom());
			else send_item(OP_CELL, pick_temperature());
		for (i = 0; i <= ncols; i++)
			if ($urandom_range(9, 0) == 0) send_item(OP_CELL, $urandom());
			else send_item(OP_DRAIN, $urandom());
	endtask

	// random ops of random length, leaves the frame anywhere
	task automatic send_noise();
		int unsigned ncols, total, len, i;
		ncols = sb.clamp_dim(sb.cols_reg, MAX_COLS);
		total = ncols * sb.clamp_dim(sb.rows_reg, MAX_ROWS);
		len = $urandom_range(2 * total + ncols + 2, 1);
		for (i = 0; i < len; i++)
			send_item($urandom_range(1, 0) ? OP_DRAIN : OP_CELL, $urandom());
	endtask

	initial begin
		int unsigned phase, start_items, cols, rows, rate, frames, f;
		logic [31:0] base;
		cell_if.valid <= 1'b0;
		cell_if.op <= OP_CELL;
		cell_if.cell_value <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_GRID_COLUMNS;
		cfg_if.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// extreme values, max rate, min base
		set_grid(3, 2, 16'hFFFF, 32'h8000_0000);
		send_item(OP_CELL, 32'h7FFF_FFFF);
		send_item(OP_CELL, 32'h8000_0000);
		send_item(OP_CELL, 32'h0000_0000);
		send_item(OP_CELL, 32'hFFFF_FFFF);
		send_item(OP_CELL, 32'h0000_0001);
		send_item(OP_CELL, 32'h5555_5555);
		repeat (4) send_item(OP_DRAIN, $urandom());
		wait_drained();

		// positive saturation, drain before the last cell, cells after the last cell
		set_grid(2, 2, 16'hFFFF, 32'h7FFF_FFFF);
		send_item(OP_CELL, 32'h7FFF_FFFF);
		send_item(OP_DRAIN, 32'h0000_0000);
		send_item(OP_CELL, 32'h7FFF_FFFF);
		send_item(OP_CELL, 32'h7FFF_FFFF);
		repeat (3) send_item(OP_CELL, $urandom());
		wait_drained();

		// partial frame, then a dimension write restarts it; zero sizes mean one
		set_grid(4, 3, 256, 0);
		repeat (6) send_item(OP_CELL, pick_temperature());
		wait_drained();
		set_grid(0, 0, 0, 32'hFFFF_FFFF);
		send_item(OP_CELL, 32'h8000_0000);
		repeat (2) send_item(OP_DRAIN, $urandom());
		wait_drained();

		// random phases, mostly well-formed frames
		phase = 0;
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS || phase < MIN_PHASES) begin
			phase++;
			steady = (phase == 5 || phase == 6);
			case ($urandom_range(9, 0))
				0: cols = 0;
				1: cols = 1;
				2: cols = 2;
				3: cols = $urandom_range(40, 9);
				default: cols = $urandom_range(8, 3);
			endcase
			case ($urandom_range(7, 0))
				0: rows = 0;
				1: rows = 1;
				default: rows = $urandom_range(6, 2);
			endcase
			case ($urandom_range(4, 0))
				0: rate = 0;
				1: rate = 16'hFFFF;
				2: rate = 256;
				3: rate = $urandom_range(512, 0);
				default: rate = $urandom_range(16'hFFFF, 0);
			endcase
			case ($urandom_range(4, 0))
				0: base = 32'h8000_0000;
				1: base = 32'h7FFF_FFFF;
				2: base = 32'h0;
				3: base = $urandom_range(32'h000F_FFFF, 0) - 32'h0008_0000;
				default: base = $urandom();
			endcase
			// long output hold-off while a full 8x8 frame is offered
			if (phase == 3) begin
				cols = 8;
				rows = 8;
			end
			set_grid(cols, rows, rate, base);
			if (phase == 3) hold_request = 1'b1;
			frames = $urandom_range(3, 1);
			for (f = 0; f < frames; f++)
				if (f + 1 == frames && $urandom_range(99, 0) < 20) send_noise();
				else send_frame();
			wait_drained();
		end
		steady = 1'b0;

		// tallest grid: one column, row count past the limit, top part only
		set_grid(1, 2047, $urandom_range(16'hFFFF, 0), pick_temperature());
		repeat (TALL_ITEMS) send_item(OP_CELL, pick_temperature());
		wait_drained();

		if (sb.expected_cells.size() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.expected_cells.size()));
		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
